FILE: rtl/core/difference_polynomial_neuron_unit_macros.svh
// Assertion macros for the difference polynomial neuron unit checker.
// Depends on nothing; included by the checker file.
`ifndef DIFFERENCE_POLYNOMIAL_NEURON_UNIT_MACROS_SVH
`define DIFFERENCE_POLYNOMIAL_NEURON_UNIT_MACROS_SVH

// Antecedent this cycle implies consequent next cycle, off during reset.
`define DPN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Same-cycle implication, live through reset.
`define DPN_ASSERT_NOW(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/core/dpn_pkg.sv
// Shared types, constants and helpers for the difference polynomial neuron unit.
// No dependencies; every other file but the assertion macro header imports this package.
`timescale 1ns / 1ps

package dpn_pkg;

   localparam int DATA_W          = 32;  // Q16.16 word
   localparam int IDX_W           = 6;   // neuron index field
   localparam int IDX_RANGE       = 1 << IDX_W;
   localparam int CSR_IDX_W       = 3;
   localparam int NUM_COEFS       = 7;
   localparam int FIRST_DIFF_TERM = 3;
   localparam int PROD_W          = 2 * DATA_W;
   localparam int TERM_W          = PROD_W - 16;  // rounded product
   localparam int ACC_W           = TERM_W + 3;   // six terms plus bias

   localparam int NEURONS_DEFAULT   = 64;
   localparam int MAX_DIFFS_DEFAULT = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEFF_COUNT     = 3'd0,
      CSR_COEF_BIAS       = 3'd1,
      CSR_COEF_ACTIVATION = 3'd2,
      CSR_COEF_LINEAR     = 3'd3,
      CSR_COEF_DIFF0      = 3'd4,
      CSR_COEF_DIFF1      = 3'd5,
      CSR_COEF_DIFF2      = 3'd6,
      CSR_COEF_DIFF3      = 3'd7
   } csr_index_type;

   // Control into the shared multiply-accumulate unit.
   typedef struct packed {
      logic                     start;   // load accumulator with init
      logic signed [DATA_W-1:0] init;
      logic                     mul_en;  // multiply op_a * op_b this cycle
      logic signed [DATA_W-1:0] op_a;
      logic signed [DATA_W-1:0] op_b;
   } mac_ctl_type;

   // Clamp a wide signed value to a 32-bit signed word.
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = $signed({{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
      lo = $signed({{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});
      if (v > hi) begin
         return hi[DATA_W-1:0];
      end else if (v < lo) begin
         return lo[DATA_W-1:0];
      end
      return v[DATA_W-1:0];
   endfunction

endpackage

FILE: rtl/core/dpn_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on dpn_pkg.
`timescale 1ns / 1ps

interface dpn_req_if;
   import dpn_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         neuron_index;
   logic signed [DATA_W-1:0] input_value;
   logic signed [DATA_W-1:0] activation_value;

   modport source (output valid, output neuron_index, output input_value,
                   output activation_value, input ready);
   modport sink   (input valid, input neuron_index, input input_value,
                   input activation_value, output ready);
endinterface

interface dpn_rsp_if;
   import dpn_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         out_neuron;
   logic signed [DATA_W-1:0] output_value;

   modport source (output valid, output out_neuron, output output_value, input ready);
   modport sink   (input valid, input out_neuron, input output_value, output ready);
endinterface

FILE: rtl/core/dpn_diff_mem.sv
// Difference store: one row of MAX_DIFFS words per neuron, registered read,
// write-to-read bypass, and a zeroing sweep after reset or on request.
// Depends on dpn_pkg.
`timescale 1ns / 1ps

module dpn_diff_mem #(
   parameter int NEURONS   = dpn_pkg::NEURONS_DEFAULT,
   parameter int MAX_DIFFS = dpn_pkg::MAX_DIFFS_DEFAULT,
   localparam int RW       = (NEURONS > 1) ? $clog2(NEURONS) : 1
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     clear_start,
   input  logic                                     rd_en,
   input  logic [RW-1:0]                            rd_row,
   output logic [MAX_DIFFS-1:0][dpn_pkg::DATA_W-1:0] rd_data,
   input  logic                                     wr_en,
   input  logic [RW-1:0]                            wr_row,
   input  logic [MAX_DIFFS-1:0][dpn_pkg::DATA_W-1:0] wr_data,
   output logic                                     busy
);
   import dpn_pkg::*;

   localparam logic [RW-1:0] LAST_ROW = RW'(NEURONS - 1);

   logic [MAX_DIFFS*DATA_W-1:0]         mem_ff [NEURONS];
   logic [MAX_DIFFS-1:0][DATA_W-1:0]    rd_data_ff;
   logic                                clr_busy_ff;
   logic                                clr_busy_in;
   logic [RW-1:0]                       clr_cnt_ff;
   logic [RW-1:0]                       clr_cnt_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clear_start) begin
         clr_busy_in = 1'b1;
         clr_cnt_in  = '0;
      end else if (clr_busy_ff) begin
         if (clr_cnt_ff == LAST_ROW) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_cnt_in = RW'(clr_cnt_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem_ff[clr_cnt_ff] <= '0;
      end else if (wr_en) begin
         mem_ff[wr_row] <= wr_data;
      end
   end

   // same-row write in the read cycle: hand back the new row
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_row == rd_row)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_row];
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

FILE: rtl/core/dpn_mac.sv
// Shared multiply-accumulate: one registered 32x32 product per cycle,
// rounded half up to Q16.16 and summed in a wide accumulator.
// Depends on dpn_pkg.
`timescale 1ns / 1ps

module dpn_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  dpn_pkg::mac_ctl_type              ctl,
   output logic signed [dpn_pkg::DATA_W-1:0] result
);
   import dpn_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [TERM_W-1:0] term;

   always_comb begin
      prod_rnd = prod_ff + PROD_W'(32'sd32768);
      term     = prod_rnd[PROD_W-1:16];  // floor shift after adding one half
      acc_in   = acc_ff;
      if (ctl.start) begin
         acc_in = {{(ACC_W-DATA_W){ctl.init[DATA_W-1]}}, ctl.init};
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctl.mul_en;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= $signed(ctl.op_a) * $signed(ctl.op_b);
      end
      acc_ff <= acc_in;
   end

   assign result = sat32(acc_ff);

endmodule

FILE: rtl/core/difference_polynomial_neuron_unit.sv
// Difference polynomial neuron unit, top level.
// Depends on dpn_pkg, dpn_if, dpn_diff_mem and dpn_mac.
`timescale 1ns / 1ps

// Each request word names a neuron and brings its net input x and activation
// f(x); the response word echoes the index with y = a0 + a1*f(x) + a2*x +
// sum a(k+3)*D[k], limited to the first coeff_count terms, all Q16.16 and
// saturated. The neuron's difference row then becomes D'[0] = y,
// D'[k] = sat(D'[k-1] - D[k-1]). One shared multiplier takes one term per
// cycle and the row update takes one difference per cycle; a word has
// m = min(count-1, 2+MAX_DIFFS) products and d = min(count-3, MAX_DIFFS)
// differences. One request word waits in a holding register while another
// is worked on, and the response register frees the request side from a
// stalled consumer. After reset and after every coeff_count write, the
// difference store is zeroed one row per cycle, with req_if.ready low
// meanwhile. Neuron indexes at or above NEURONS wrap modulo NEURONS
// for the row.
module difference_polynomial_neuron_unit #(
   parameter int NEURONS   = dpn_pkg::NEURONS_DEFAULT,
   parameter int MAX_DIFFS = dpn_pkg::MAX_DIFFS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   dpn_req_if.sink                         req_if,
   dpn_rsp_if.source                       rsp_if,
   input  logic                            csr_write_enable,
   input  logic [dpn_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dpn_pkg::DATA_W-1:0]      csr_write_data
);
   import dpn_pkg::*;

   localparam int RW  = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam int DIW = (MAX_DIFFS > 1) ? $clog2(MAX_DIFFS) : 1;
   localparam logic [2:0] MD      = 3'(MAX_DIFFS);
   localparam logic [2:0] MUL_MAX = 3'(MAX_DIFFS + 2);
   localparam logic [2:0] T_DIFF0 = 3'(FIRST_DIFF_TERM - 1);  // first diff product
   localparam logic [2:0] CNT_D0  = 3'(FIRST_DIFF_TERM);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MUL    = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_UPDATE = 5'b10000
   } seq_state_type;

   typedef logic [MAX_DIFFS-1:0][DATA_W-1:0] row_type;

   // configuration
   logic [2:0]               count_ff;
   logic signed [DATA_W-1:0] coef_ff [NUM_COEFS];

   // holding register for the next request word
   logic                     pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]         pend_idx_ff, pend_idx_in;
   logic signed [DATA_W-1:0] pend_x_ff, pend_x_in;
   logic signed [DATA_W-1:0] pend_fx_ff, pend_fx_in;

   // word in flight
   seq_state_type            state_ff, state_in;
   logic [IDX_W-1:0]         cur_idx_ff, cur_idx_in;
   logic signed [DATA_W-1:0] cur_x_ff, cur_x_in;
   logic signed [DATA_W-1:0] cur_fx_ff, cur_fx_in;
   logic [RW-1:0]            row_ff, row_in;
   logic [2:0]               t_ff, t_in;
   logic [DIW-1:0]           k_ff, k_in;
   logic signed [DATA_W-1:0] carry_ff, carry_in;
   row_type                  newrow_ff, newrow_in;

   // response register
   logic                     out_vld_ff, out_vld_in;
   logic [IDX_W-1:0]         out_idx_ff, out_idx_in;
   logic signed [DATA_W-1:0] out_val_ff, out_val_in;

   logic [RW-1:0]            row_lut [IDX_RANGE];
   logic [2:0]               nmul, ndiff, cnt_m1, cnt_m3;
   logic [DIW-1:0]           k_last;
   logic                     req_accept, out_free, finish_ok, last_step, go;
   logic                     mem_busy, clear_start, rd_en, wr_en;
   row_type                  rd_data, wr_data;
   mac_ctl_type              mac_ctl;
   logic signed [DATA_W-1:0] mac_result;
   logic signed [DATA_W-1:0] d_k;
   logic signed [DATA_W:0]   diff_wide;
   logic signed [DATA_W-1:0] next_carry;

   // row = index modulo NEURONS, as a constant table
   for (genvar g = 0; g < IDX_RANGE; g++) begin : g_row_lut
      assign row_lut[g] = RW'(g % NEURONS);
   end

   // configuration writes; a count write also restarts the store sweep
   assign clear_start = csr_write_enable && (csr_index == CSR_COEFF_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (clear_start) begin
         count_ff <= csr_write_data[2:0];
      end else if (csr_write_enable) begin
         coef_ff[3'(csr_index - CSR_COEF_BIAS)] <= $signed(csr_write_data);
      end
   end

   // term counts from the coefficient count
   always_comb begin
      cnt_m1 = 3'(count_ff - 3'd1);
      cnt_m3 = 3'(count_ff - CNT_D0);
      if (count_ff == '0) begin
         nmul = '0;
      end else if (cnt_m1 > MUL_MAX) begin
         nmul = MUL_MAX;
      end else begin
         nmul = cnt_m1;
      end
      if (count_ff <= CNT_D0) begin
         ndiff = '0;
      end else if (cnt_m3 > MD) begin
         ndiff = MD;
      end else begin
         ndiff = cnt_m3;
      end
      k_last = DIW'(ndiff - 3'd1);
   end

   assign req_accept = req_if.valid && req_if.ready;
   assign out_free   = !out_vld_ff || rsp_if.ready;

   // one step of the difference chain
   always_comb begin
      d_k        = $signed(rd_data[k_ff]);
      diff_wide  = {carry_ff[DATA_W-1], carry_ff} - {d_k[DATA_W-1], d_k};
      next_carry = sat32(ACC_W'(diff_wide));
      wr_data        = newrow_ff;
      wr_data[k_ff]  = carry_ff;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      pend_vld_in = pend_vld_ff;
      pend_idx_in = pend_idx_ff;
      pend_x_in   = pend_x_ff;
      pend_fx_in  = pend_fx_ff;
      cur_idx_in  = cur_idx_ff;
      cur_x_in    = cur_x_ff;
      cur_fx_in   = cur_fx_ff;
      row_in      = row_ff;
      t_in        = t_ff;
      k_in        = k_ff;
      carry_in    = carry_ff;
      newrow_in   = newrow_ff;
      out_vld_in  = out_vld_ff;
      out_idx_in  = out_idx_ff;
      out_val_in  = out_val_ff;
      mac_ctl     = '0;
      rd_en       = 1'b0;
      wr_en       = 1'b0;

      finish_ok = (state_ff == ST_FINISH) && out_free;
      last_step = (finish_ok && (ndiff == '0)) ||
                  ((state_ff == ST_UPDATE) && (k_ff == k_last));
      go        = pend_vld_ff && (((state_ff == ST_IDLE) && !mem_busy) || last_step);

      if (req_accept) begin
         pend_vld_in = 1'b1;
         pend_idx_in = req_if.neuron_index;
         pend_x_in   = req_if.input_value;
         pend_fx_in  = req_if.activation_value;
      end else if (go) begin
         pend_vld_in = 1'b0;
      end

      if (out_vld_ff && rsp_if.ready) begin
         out_vld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_MUL: begin
            mac_ctl.mul_en = 1'b1;
            mac_ctl.op_a   = coef_ff[3'(t_ff + 3'd1)];  // a1 for term 0
            if (t_ff == 3'd0) begin
               mac_ctl.op_b = cur_fx_ff;
            end else if (t_ff == 3'd1) begin
               mac_ctl.op_b = cur_x_ff;
            end else begin
               mac_ctl.op_b = $signed(rd_data[DIW'(t_ff - T_DIFF0)]);
            end
            t_in = 3'(t_ff + 3'd1);
            if (t_ff == 3'(nmul - 3'd1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;  // last product lands in the accumulator
         end
         ST_FINISH: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_idx_in = cur_idx_ff;
               out_val_in = mac_result;
               carry_in   = mac_result;
               newrow_in  = rd_data;
               k_in       = '0;
               state_in   = (ndiff == '0) ? ST_IDLE : ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            newrow_in[k_ff] = carry_ff;
            carry_in        = next_carry;
            k_in            = DIW'(k_ff + 1'b1);
            if (k_ff == k_last) begin
               wr_en    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // launch the held word; its read may overlap the previous write-back
      if (go) begin
         cur_idx_in     = pend_idx_ff;
         cur_x_in       = pend_x_ff;
         cur_fx_in      = pend_fx_ff;
         row_in         = row_lut[pend_idx_ff];
         rd_en          = 1'b1;
         mac_ctl.start  = 1'b1;
         mac_ctl.init   = (count_ff == '0) ? '0 : coef_ff[0];
         t_in           = '0;
         state_in       = (nmul != '0) ? ST_MUL : ST_DRAIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         t_ff        <= '0;
         k_ff        <= '0;
      end else begin
         state_ff    <= state_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
         t_ff        <= t_in;
         k_ff        <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      pend_x_ff   <= pend_x_in;
      pend_fx_ff  <= pend_fx_in;
      cur_idx_ff  <= cur_idx_in;
      cur_x_ff    <= cur_x_in;
      cur_fx_ff   <= cur_fx_in;
      row_ff      <= row_in;
      carry_ff    <= carry_in;
      newrow_ff   <= newrow_in;
      out_idx_ff  <= out_idx_in;
      out_val_ff  <= out_val_in;
   end

   dpn_diff_mem #(
      .NEURONS   (NEURONS),
      .MAX_DIFFS (MAX_DIFFS)
   ) u_diff_mem (
      .clock       (clock),
      .reset       (reset),
      .clear_start (clear_start),
      .rd_en       (rd_en),
      .rd_row      (row_lut[pend_idx_ff]),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_row      (row_ff),
      .wr_data     (wr_data),
      .busy        (mem_busy)
   );

   dpn_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .result (mac_result)
   );

   assign req_if.ready        = !pend_vld_ff && !mem_busy;
   assign rsp_if.valid        = out_vld_ff;
   assign rsp_if.out_neuron   = out_idx_ff;
   assign rsp_if.output_value = out_val_ff;

endmodule

FILE: rtl/core/dpn_checker.sv
// Port-level checks for the difference polynomial neuron unit, bound to the top.
// Depends on dpn_pkg and difference_polynomial_neuron_unit_macros.svh.
`timescale 1ns / 1ps
`include "difference_polynomial_neuron_unit_macros.svh"

module dpn_port_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          csr_write_enable,
   input logic [dpn_pkg::CSR_IDX_W-1:0] csr_index,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dpn_pkg::IDX_W-1:0]     rsp_out_neuron,
   input logic [dpn_pkg::DATA_W-1:0]    rsp_output_value
);
   import dpn_pkg::*;

   logic                      count_write;
   logic                      rsp_stall;
   logic [IDX_W+DATA_W-1:0]   rsp_word;

   assign count_write = csr_write_enable && (csr_index == CSR_COEFF_COUNT);
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_word    = {rsp_out_neuron, rsp_output_value};

   `DPN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid, "rsp word dropped in stall")
   `DPN_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_word), "rsp word changed")
   `DPN_ASSERT_NEXT(a_clear_blocks_req, clock, reset, count_write, !req_ready, "req during sweep")
   `DPN_ASSERT_NOW(a_reset_no_rsp, clock, $past(reset), !rsp_valid, "rsp valid right after reset")
   `DPN_ASSERT_NOW(a_reset_sweep, clock, $past(reset), !req_ready, "req ready during reset sweep")

endmodule

bind difference_polynomial_neuron_unit dpn_port_checker u_dpn_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_if.ready),
   .csr_write_enable (csr_write_enable),
   .csr_index        (csr_index),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_out_neuron   (rsp_if.out_neuron),
   .rsp_output_value (rsp_if.output_value)
);

FILE: tb/dpn_checker.sv
// Scoreboard for the difference polynomial neuron unit: watches the request, response and
// CSR ports, predicts each response word and compares it field by field.
// Depends on dpn_pkg and the dpn_req_if / dpn_rsp_if interfaces.
`timescale 1ns / 1ps

module dpn_checker (
   input  logic                          clock,
   input  logic                          reset,
   dpn_req_if                            req_mon,
   dpn_rsp_if                            rsp_mon,
   input  logic                          csr_write_enable,
   input  logic [dpn_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dpn_pkg::DATA_W-1:0]    csr_write_data,
   output int                            mismatch_count,
   output int                            outstanding_count,
   output int                            checked_count
);
   import dpn_pkg::*;

   localparam int ROWS  = NEURONS_DEFAULT;
   localparam int DIFFS = MAX_DIFFS_DEFAULT;
   localparam longint WORD_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint WORD_MIN = -64'sh0000_0000_8000_0000;

   typedef struct packed {
      logic [IDX_W-1:0]         neuron;
      logic signed [DATA_W-1:0] value;
   } neuron_output_type;

   neuron_output_type        predicted_outputs[$];
   logic [2:0]               term_count;
   logic signed [DATA_W-1:0] gain [NUM_COEFS];
   logic signed [DATA_W-1:0] history [ROWS][DIFFS];
   int                       errors = 0;
   int                       checked = 0;

   function automatic longint clamp_word(input longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   // Q16.16 product, exact in 64 bits, rounded half up.
   function automatic longint fixed_product(input logic signed [DATA_W-1:0] a,
                                            input logic signed [DATA_W-1:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return (p + 64'sd32768) >>> 16;
   endfunction

   // New output of one neuron; rebuilds its difference row as a side effect.
   function automatic logic signed [DATA_W-1:0] advance_neuron(
         input logic [IDX_W-1:0] idx,
         input logic signed [DATA_W-1:0] x,
         input logic signed [DATA_W-1:0] fx);
      int                       row;
      int                       chain;
      longint                   acc;
      longint                   carry;
      longint                   next_diff;
      logic signed [DATA_W-1:0] y;
      row   = int'(idx) % ROWS;
      chain = (term_count > FIRST_DIFF_TERM) ? int'(term_count) - FIRST_DIFF_TERM : 0;
      if (chain > DIFFS) chain = DIFFS;
      if (term_count == 0) return '0;
      acc = longint'(gain[0]);
      if (term_count >= 2) acc += fixed_product(gain[1], fx);
      if (term_count >= 3) acc += fixed_product(gain[2], x);
      for (int k = 0; k < chain; k++)
         acc += fixed_product(gain[FIRST_DIFF_TERM + k], history[row][k]);
      y = 32'(clamp_word(acc));
      carry = longint'(y);
      for (int k = 0; k < chain; k++) begin
         next_diff = clamp_word(carry - longint'(history[row][k]));
         history[row][k] = 32'(carry);
         carry = next_diff;
      end
      return y;
   endfunction

   always @(posedge clock) begin
      neuron_output_type oldest;
      neuron_output_type fresh;
      if (reset) begin
         predicted_outputs.delete();
         term_count = '0;
         foreach (gain[i]) gain[i] = '0;
         foreach (history[r, d]) history[r][d] = '0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_COEFF_COUNT) begin
               term_count = csr_write_data[2:0];
               foreach (history[r, d]) history[r][d] = '0;
            end else begin
               gain[int'(csr_index) - int'(CSR_COEF_BIAS)] = csr_write_data;
            end
         end
         // response first: it can never belong to a request taken at this same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_outputs.size() == 0) begin
               $error("unexpected response word: neuron %0d, value %h",
                      rsp_mon.out_neuron, rsp_mon.output_value);
               errors++;
            end else begin
               oldest = predicted_outputs.pop_front();
               checked++;
               if (rsp_mon.out_neuron !== oldest.neuron) begin
                  $error("out_neuron mismatch: expected %0d, actual %0d",
                         oldest.neuron, rsp_mon.out_neuron);
                  errors++;
               end
               if (rsp_mon.output_value !== oldest.value) begin
                  $error("output_value mismatch (neuron %0d): expected %h, actual %h",
                         oldest.neuron, oldest.value, rsp_mon.output_value);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            fresh.neuron = req_mon.neuron_index;
            fresh.value  = advance_neuron(req_mon.neuron_index, req_mon.input_value,
                                          req_mon.activation_value);
            predicted_outputs.push_back(fresh);
         end
      end
      mismatch_count    <= errors;
      outstanding_count <= predicted_outputs.size();
      checked_count     <= checked;
   end

endmodule

FILE: tb/tb_top.sv
// Top of the neuron unit testbench: clock, reset, request stimulus, response back-pressure,
// CSR programming, watchdog and verdict. Checking lives in dpn_checker.
// Depends on dpn_pkg, dpn_if, difference_polynomial_neuron_unit and dpn_checker.
`timescale 1ns / 1ps

module tb_top;
   import dpn_pkg::*;

   localparam int HALF_PERIOD       = 10;
   localparam int RESET_CYCLES      = 8;
   // covers the worst word plus the response register, rounded up generously
   localparam int DRAIN_CYCLES      = 24;
   // longest legal quiet spell: store clear, drain wait, long receiver hold
   localparam int STALL_LIMIT       = 3000;
   localparam int LONG_HOLD         = 300;
   localparam int RANDOM_SETTINGS   = 8;
   localparam int WORDS_PER_SETTING = 100;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_write_data;

   dpn_req_if req_bus ();
   dpn_rsp_if rsp_bus ();

   int mismatch_count;
   int outstanding_count;
   int checked_count;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_toggle   = 1'b0;   // each flip asks the receiver for one long hold-off
   int  words_sent    = 0;
   int  settings_loaded = 0;
   int  idle_cycles   = 0;

   logic signed [DATA_W-1:0] gains [NUM_COEFS];   // a0..a6 for the next program_setting
   logic [IDX_W-1:0]         hot_neurons [4];     // neurons revisited to grow their chains

   difference_polynomial_neuron_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   dpn_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_bus),
      .rsp_mon           (rsp_bus),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count),
      .checked_count     (checked_count)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Watchdog: any accepted word on either side restarts the count.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Response side: random back-pressure, plus a long hold-off on request so the
   // holding and response registers fill and the request side stalls.
   initial begin
      int hold_left;
      bit seen_toggle;
      hold_left   = 0;
      seen_toggle = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_toggle != seen_toggle) begin
            seen_toggle = hold_toggle;
            hold_left   = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // One register write per edge; the caller drops the enable after the last one.
   task automatic write_reg(input csr_index_type which, input logic [DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= which;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // Count first (clears the store), then all seven gains.
   task automatic program_setting(input logic [2:0] count);
      write_reg(CSR_COEFF_COUNT, {29'b0, count});
      for (int i = 0; i < NUM_COEFS; i++)
         write_reg(csr_index_type'(int'(CSR_COEF_BIAS) + i), gains[i]);
      csr_write_enable <= 1'b0;
      settings_loaded++;
   endtask

   // Wait until every predicted word came back, then let the pipeline go quiet.
   // The first edge lets the checker count the last accepted request.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_word(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] x,
                            input logic [DATA_W-1:0] fx);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.neuron_index     <= idx;
      req_bus.input_value      <= x;
      req_bus.activation_value <= fx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
   endtask

   // Mix of rails, zero, values within +-4.0 (keeps difference chains alive),
   // tiny values that exercise rounding, and full-width noise.
   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3, 4, 5: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         6:       return $urandom_range(0, 32'h0000_2000) - 32'h0000_1000;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int                  setting_counts [RANDOM_SETTINGS];
      logic [IDX_W-1:0]    idx;
      csr_index_type       which;
      logic [DATA_W-1:0]   data;

      reset                    <= 1'b1;
      csr_write_enable         <= 1'b0;
      csr_index                <= CSR_COEFF_COUNT;
      csr_write_data           <= '0;
      req_bus.valid            <= 1'b0;
      req_bus.neuron_index     <= '0;
      req_bus.input_value      <= '0;
      req_bus.activation_value <= '0;
      setting_counts = '{7, 7, 0, 4, 5, 6, 3, 2};

      // sender idles 30%, receiver 53%
      send_idle_pct = 30;
      recv_idle_pct = 53;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // Reset state: count zero, so y = 0 whatever the inputs; rails and both index ends.
      // Acceptance here also proves the post-reset clear has finished.
      send_word(6'd0,  32'h7FFF_FFFF, 32'h8000_0000);
      send_word(6'd63, 32'h8000_0000, 32'h7FFF_FFFF);

      // Count zero with live gains: still zero.
      settle();
      gains = '{32'h1234_5678, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
      program_setting(3'd0);
      send_word(6'd21, 32'h0001_0000, 32'h0001_0000);

      // Count one: bias only.
      settle();
      gains = '{32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0};
      program_setting(3'd1);
      send_word(6'd1, $urandom, $urandom);

      // Count two: huge activation gain saturates high and low; x is not used.
      settle();
      gains = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0};
      program_setting(3'd2);
      send_word(6'd2, 32'h0000_0000, 32'h7FFF_FFFF);
      send_word(6'd2, 32'h0000_0000, 32'h8000_0000);
      send_word(6'd2, 32'h7FFF_FFFF, 32'h0000_0000);

      // Count three: gains of one LSB show rounding, +0.5 LSB up and -0.5 LSB to zero.
      settle();
      gains = '{0, 32'h0000_0001, 32'h0000_0001, 0, 0, 0, 0};
      program_setting(3'd3);
      send_word(6'd3, 32'h0000_8000, 32'h0000_0000);
      send_word(6'd3, 32'hFFFF_8000, 32'h0000_0000);
      send_word(6'd3, 32'h8000_0000, 32'h7FFF_FFFF);

      // Count seven: build neuron 5's difference chain, one word for neuron 62 in between.
      settle();
      gains = '{32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_8000,
                32'hFFFF_0000, 32'h0000_4000, 32'h7FFF_FFFF};
      program_setting(3'd7);
      send_word(6'd5,  $urandom, 32'h0001_0000);
      send_word(6'd5,  $urandom, 32'h0002_0000);
      send_word(6'd5,  $urandom, 32'hFFFE_0000);
      send_word(6'd62, $urandom, 32'h0003_0000);
      send_word(6'd5,  $urandom, 32'h0003_0000);
      send_word(6'd5,  $urandom, 32'h0000_0000);

      // Rewriting a gain keeps the store.
      settle();
      write_reg(CSR_COEF_BIAS, 32'hFFFF_0000);
      csr_write_enable <= 1'b0;
      send_word(6'd5, $urandom, 32'h0001_0000);
      send_word(6'd5, $urandom, 32'h0001_0000);

      // Rewriting the count with the same value still clears every row.
      settle();
      write_reg(CSR_COEFF_COUNT, 32'd7);
      csr_write_enable <= 1'b0;
      send_word(6'd5, $urandom, 32'h0001_0000);
      send_word(6'd5, $urandom, 32'h0001_0000);

      // Count five, all gains at the top rail: alternating rails saturate the differences.
      settle();
      foreach (gains[i]) gains[i] = 32'h7FFF_FFFF;
      program_setting(3'd5);
      send_word(6'd63, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_word(6'd63, 32'h8000_0000, 32'h8000_0000);
      send_word(6'd63, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

      // ---- random settings ----
      for (int s = 0; s < RANDOM_SETTINGS; s++) begin
         // idling: A for the first three, swapped for the next three, none for the rest
         if (s >= 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (s >= 3) begin
            send_idle_pct = 53;
            recv_idle_pct = 30;
         end
         settle();
         foreach (gains[i]) begin
            if (s == 0)      gains[i] = 32'h7FFF_FFFF;
            else if (s == 1) gains[i] = 32'h8000_0000;
            else             gains[i] = pick_word();
         end
         program_setting(3'(setting_counts[s]));
         foreach (hot_neurons[i]) hot_neurons[i] = 6'($urandom_range(0, 63));

         for (int n = 0; n < WORDS_PER_SETTING; n++) begin
            if (n == 10 && (s == 1 || s == 6)) hold_toggle <= ~hold_toggle;
            // halfway: one random register rewrite while idle
            if (n == WORDS_PER_SETTING / 2) begin
               settle();
               which = csr_index_type'($urandom_range(0, 7));
               data  = (which == CSR_COEFF_COUNT) ? 32'($urandom_range(0, 7)) : pick_word();
               write_reg(which, data);
               csr_write_enable <= 1'b0;
            end
            if ($urandom_range(0, 99) < 75) idx = hot_neurons[$urandom_range(0, 3)];
            else                            idx = 6'($urandom_range(0, 63));
            send_word(idx, pick_word(), pick_word());
         end
      end

      settle();
      $display("covered %0d request words over %0d coefficient settings (counts 0..7, rails)",
               words_sent, settings_loaded);
      $display("responses checked: %0d, mismatches: %0d", checked_count, mismatch_count);
      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
